/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Command and status codes, controller states and the control structs that
// pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam logic [2:0] CMD_PUSH_REAR  = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_POP_REAR   = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_READ = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_POP_FRONT  = 3'd4
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_value;
      logic       exec;
      op_type     op;
      logic [1:0] status;
      logic       read;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic empty;
      logic full;
   } dp_stat_type;

endpackage

/* rtl/cdq_if.sv */
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
interface cdq_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   command;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, command, value, input ready);
   modport sink   (input valid, command, value, output ready);
endinterface

interface cdq_rsp_if #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_WIDTH  = 5
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic signed [DATA_WIDTH-1:0] front_value;
   logic signed [DATA_WIDTH-1:0] rear_value;
   logic [CNT_WIDTH-1:0]         item_count;
   logic                         empty_flag;
   logic                         is_full;

   modport source (output valid, status, front_value, rear_value, item_count,
                   empty_flag, is_full, input ready);
   modport sink   (input valid, status, front_value, rear_value, item_count,
                   empty_flag, is_full, output ready);
endinterface

/* rtl/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for one request: latch, execute, read back the ends, respond.
// ----------------------------------------------------------------------------
module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_command,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   state_type  state_ff, state_in;
   logic [2:0] command_ff, command_in;
   op_type     op;
   logic [1:0] status;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // Decode the latched command against the current fill level.
   always_comb begin
      op     = OP_NONE;
      status = ST_OK;
      case (command_ff)
         CMD_PUSH_REAR: begin
            if (dp_stat.full) status = ST_OVERFLOW;
            else              op     = OP_PUSH_REAR;
         end
         CMD_PUSH_FRONT: begin
            if (dp_stat.full) status = ST_OVERFLOW;
            else              op     = OP_PUSH_FRONT;
         end
         CMD_POP_REAR: begin
            if (dp_stat.empty) status = ST_UNDERFLOW;
            else               op     = OP_POP_REAR;
         end
         CMD_POP_FRONT: begin
            if (dp_stat.empty) status = ST_UNDERFLOW;
            else               op     = OP_POP_FRONT;
         end
         // Query and the unused codes leave the state alone.
         default: begin
            op     = OP_NONE;
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      command_in = command_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               command_in = req_command;
               state_in   = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_READ;
         S_READ:  state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.load_value = (state_ff == S_IDLE) && req_valid;
      dp_cmd.exec       = (state_ff == S_EXEC);
      dp_cmd.op         = (state_ff == S_EXEC) ? op : OP_NONE;
      dp_cmd.status     = status;
      dp_cmd.read       = (state_ff == S_READ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not start execution");

   a_exec_read_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_READ) ##1 rsp_valid)
      else $error("execution did not lead to a response");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && !req_ready))
      else $error("stalled response lost or new request taken");

endmodule

/* rtl/cdq_dpath.sv */
// ----------------------------------------------------------------------------
// cdq_dpath
// Circular slot store with head and tail indices, fill count and the
// response registers.
// ----------------------------------------------------------------------------
module cdq_dpath
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int IDX_WIDTH  = $clog2(DEPTH),
   parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  dp_cmd_type                   dp_cmd,
   output dp_stat_type                  dp_stat,
   output logic [1:0]                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_front_value,
   output logic signed [DATA_WIDTH-1:0] rsp_rear_value,
   output logic [CNT_WIDTH-1:0]         rsp_item_count,
   output logic                         rsp_empty_flag,
   output logic                         rsp_is_full
);

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [IDX_WIDTH-1:0]  head_ff, head_in;
   logic [IDX_WIDTH-1:0]  tail_ff, tail_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [1:0]            status_ff;
   logic [DATA_WIDTH-1:0] front_ff, rear_ff;

   logic                  wr_en;
   logic [IDX_WIDTH-1:0]  wr_addr;
   logic [IDX_WIDTH-1:0]  head_prev, head_next, tail_prev, tail_next;

   function automatic logic [IDX_WIDTH-1:0] idx_next(input logic [IDX_WIDTH-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_WIDTH-1:0] idx_prev(input logic [IDX_WIDTH-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   assign head_prev = idx_prev(head_ff);
   assign head_next = idx_next(head_ff);
   assign tail_prev = idx_prev(tail_ff);
   assign tail_next = idx_next(tail_ff);

   assign dp_stat.empty = (count_ff == '0);
   assign dp_stat.full  = (count_ff == FULL_CNT);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      case (dp_cmd.op)
         OP_PUSH_REAR: begin
            wr_en    = 1'b1;
            wr_addr  = tail_ff;
            tail_in  = tail_next;
            count_in = count_ff + 1'b1;
         end
         OP_PUSH_FRONT: begin
            // The head steps back, wrapping from slot zero to the last slot.
            wr_en    = 1'b1;
            wr_addr  = head_prev;
            head_in  = head_prev;
            count_in = count_ff + 1'b1;
         end
         OP_POP_REAR: begin
            tail_in  = tail_prev;
            count_in = count_ff - 1'b1;
         end
         OP_POP_FRONT: begin
            head_in  = head_next;
            count_in = count_ff - 1'b1;
         end
         default: begin
            head_in  = head_ff;
            tail_in  = tail_ff;
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // The read happens in the cycle after the write, so it sees the new entry.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= value_ff;
      if (dp_cmd.read) begin
         front_ff <= mem[head_ff];
         rear_ff  <= mem[tail_prev];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_value) value_ff <= req_value;
      if (dp_cmd.exec)       status_ff <= dp_cmd.status;
   end

   assign rsp_status      = status_ff;
   assign rsp_front_value = dp_stat.empty ? '0 : front_ff;
   assign rsp_rear_value  = dp_stat.empty ? '0 : rear_ff;
   assign rsp_item_count  = count_ff;
   assign rsp_empty_flag  = dp_stat.empty;
   assign rsp_is_full     = dp_stat.full;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count above capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.exec && dp_cmd.status == ST_OVERFLOW) |=> $stable(count_ff))
      else $error("refused push changed the fill count");

endmodule

/* rtl/circular_deque_top.sv */
// ----------------------------------------------------------------------------
// circular_deque_top
// Fixed-capacity double-ended queue in a circular slot store.
// ----------------------------------------------------------------------------
// Each request carries a command (push rear, push front, pop rear, pop front,
// query) and a data word, and returns exactly one response with the status,
// the front and rear entries after the command (zero when empty), the count
// and the empty and full flags. A push into a full deque or a pop from an
// empty one is refused with overflow or underflow and leaves the contents
// alone. One request is handled at a time: it is accepted, executed in the
// next cycle, the slot store is read at the head and rear in the cycle after,
// and the response is then presented and held until it is taken. The
// sequence is set by the registered reads of the slot store after its write.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module circular_deque_top
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   cdq_req_if.sink    req_ch,
   cdq_rsp_if.source  rsp_ch
);

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .dp_stat     (dp_stat),
      .dp_cmd      (dp_cmd)
   );

   cdq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_ch.value),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .rsp_status      (rsp_ch.status),
      .rsp_front_value (rsp_ch.front_value),
      .rsp_rear_value  (rsp_ch.rear_value),
      .rsp_item_count  (rsp_ch.item_count),
      .rsp_empty_flag  (rsp_ch.empty_flag),
      .rsp_is_full     (rsp_ch.is_full)
   );

endmodule

/* sim/deque_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response channels of the circular deque. It keeps
// its own copy of the deque contents and checks each response against it.
// ----------------------------------------------------------------------------
module deque_checker
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
   input  logic clock,
   input  logic reset,
   cdq_req_if   req_mon,
   cdq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      logic [1:0]            status;
      logic [DATA_WIDTH-1:0] front_value;
      logic [DATA_WIDTH-1:0] rear_value;
      logic [CNT_WIDTH-1:0]  item_count;
      logic                  empty_flag;
      logic                  is_full;
   } deque_view_type;

   logic [DATA_WIDTH-1:0] slot_copy [DEPTH];
   int                    head_slot = 0;
   int                    tail_slot = 0;
   int                    held      = 0;
   int                    mismatch_total = 0;
   deque_view_type        predicted_views [$];

   assign mismatch_count = mismatch_total;

   function automatic int wrap_next(input int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int wrap_prev(input int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // Applies one command to the local copy and returns the view after it.
   task automatic apply_command(input logic [2:0] cmd, input logic [DATA_WIDTH-1:0] word,
                                output deque_view_type view);
      view = '0;
      view.status = ST_OK;
      case (cmd)
         CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
            if (held >= DEPTH) begin
               view.status = ST_OVERFLOW;
            end else if (cmd == CMD_PUSH_REAR) begin
               slot_copy[tail_slot] = word;
               tail_slot = wrap_next(tail_slot);
               held++;
            end else begin
               // A front push at slot zero wraps the head to the last slot.
               head_slot = wrap_prev(head_slot);
               slot_copy[head_slot] = word;
               held++;
            end
         end
         CMD_POP_REAR, CMD_POP_FRONT: begin
            if (held == 0) begin
               view.status = ST_UNDERFLOW;
            end else if (cmd == CMD_POP_REAR) begin
               tail_slot = wrap_prev(tail_slot);
               held--;
            end else begin
               head_slot = wrap_next(head_slot);
               held--;
            end
         end
         default: begin
            // Query and the unused codes leave the contents alone.
         end
      endcase
      if (held != 0) begin
         view.front_value = slot_copy[head_slot];
         view.rear_value  = slot_copy[wrap_prev(tail_slot)];
      end
      view.item_count = CNT_WIDTH'(held);
      view.empty_flag = (held == 0);
      view.is_full    = (held >= DEPTH);
   endtask

   task automatic report_field(input string field, input logic [DATA_WIDTH-1:0] want,
                               input logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         head_slot = 0;
         tail_slot = 0;
         held      = 0;
         predicted_views.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_views.size() == 0) begin
               $display("%0t: response with no request waiting, expected none, actual %h",
                        $time, rsp_mon.status);
               mismatch_total++;
            end else begin
               want = predicted_views.pop_front();
               report_field("status", DATA_WIDTH'(want.status),
                            DATA_WIDTH'(rsp_mon.status));
               report_field("front_value", want.front_value, rsp_mon.front_value);
               report_field("rear_value", want.rear_value, rsp_mon.rear_value);
               report_field("item_count", DATA_WIDTH'(want.item_count),
                            DATA_WIDTH'(rsp_mon.item_count));
               report_field("empty_flag", DATA_WIDTH'(want.empty_flag),
                            DATA_WIDTH'(rsp_mon.empty_flag));
               report_field("is_full", DATA_WIDTH'(want.is_full),
                            DATA_WIDTH'(rsp_mon.is_full));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_command(req_mon.command, req_mon.value, want);
            predicted_views.push_back(want);
         end
      end
      outstanding <= predicted_views.size();
   end

endmodule

/* sim/tb_circular_deque_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_top
// Drives requests into the circular deque in random bursts and stalls the
// response side, including one long hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_circular_deque_top;
   import cdq_pkg::*;

   localparam int DEPTH           = 16;
   localparam int DATA_WIDTH      = 32;
   localparam int CNT_WIDTH       = $clog2(DEPTH + 1);
   localparam int RANDOM_REQUESTS = 400;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_START      = 800;
   localparam int HOLD_CYCLES     = 300;

   // Codes outside the defined set; the block treats them as a query.
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   in_flight;
   int   burst_left = 1;

   cdq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
   cdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_WIDTH(CNT_WIDTH)) rsp_if ();

   circular_deque_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   deque_checker #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CNT_WIDTH)
   ) result_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatches),
      .outstanding    (in_flight)
   );

   always #5 clock = ~clock;

   function automatic logic [DATA_WIDTH-1:0] extreme_word(input int k);
      case (k % 4)
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_word();
      if ($urandom_range(0, 7) == 0) return extreme_word($urandom_range(0, 3));
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_command(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return CMD_UNUSED_FIRST + 3'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      if (roll < 95) return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
      return CMD_QUERY;
   endfunction

   // Offers one request and returns once it is taken; at the end of a burst
   // valid may drop for a random gap.
   task automatic send_request(input logic [2:0] cmd, input logic [DATA_WIDTH-1:0] word);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.value   <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Response side: random ready patterns, plus one long hold-off while the
   // sender keeps offering requests.
   initial begin
      int cycle_no;
      int mode_left;
      int ready_pct;
      cycle_no  = 0;
      mode_left = 0;
      ready_pct = 100;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0:       ready_pct = 100;
               1:       ready_pct = 60;
               default: ready_pct = 25;
            endcase
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) < ready_pct);
         end
         cycle_no++;
         @(posedge clock);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int push_pct;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_QUERY;
      req_if.value   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty deque: a query, then both pops, which underflow.
      send_request(CMD_QUERY, 32'h1234_5678);
      send_request(CMD_POP_REAR, 32'hFFFF_FFFF);
      send_request(CMD_POP_FRONT, 32'h0000_0000);
      // The first front push wraps the head from slot zero to the last slot.
      send_request(CMD_PUSH_FRONT, 32'h8000_0000);
      send_request(CMD_PUSH_REAR, 32'h7FFF_FFFF);
      for (logic [3:0] c = 4'(CMD_UNUSED_FIRST); c <= 4'(CMD_UNUSED_LAST); c++) begin
         send_request(c[2:0], 32'hAAAA_AAAA);
      end
      send_request(CMD_POP_REAR, 32'h5555_5555);
      send_request(CMD_POP_FRONT, 32'h5555_5555);
      // Fill from both ends, then try both pushes on a full deque.
      for (int i = 0; i < DEPTH; i++) begin
         send_request(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR,
                      (i < 4) ? extreme_word(i) : $urandom);
      end
      send_request(CMD_PUSH_REAR, 32'hAAAA_AAAA);
      send_request(CMD_PUSH_FRONT, 32'h5555_5555);
      send_request(CMD_QUERY, 32'h0000_0000);

      // Random part in phases that lean toward filling, draining or neither.
      push_pct = 50;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         send_request(pick_command(push_pct), pick_word());
      end
      req_if.valid <= 1'b0;

      do @(posedge clock); while (in_flight != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque_top.sv
sim/deque_checker.sv
sim/tb_circular_deque_top.sv
